[sv/polynomial_easing_unit_core_defines.svh]
// Assertion macros used by the easing unit core RTL.
`ifndef POLYNOMIAL_EASING_UNIT_CORE_DEFINES_SVH
`define POLYNOMIAL_EASING_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PEMU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PEMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pemu_pkg.sv]
package pemu_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int MODE_BITS     = 4;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_LINEAR      = 4'd0,
        MODE_IN_QUAD     = 4'd1,
        MODE_IN_CUBIC    = 4'd2,
        MODE_IN_QUART    = 4'd3,
        MODE_OUT_QUAD    = 4'd4,
        MODE_R_IN_QUAD   = 4'd5,
        MODE_R_IN_CUBIC  = 4'd6,
        MODE_R_IN_QUART  = 4'd7,
        MODE_R_OUT_QUAD  = 4'd8,
        MODE_POP         = 4'd9
    } t_mode;

    typedef enum logic [2:0] {
        SH_LIN   = 3'd0,
        SH_QUAD  = 3'd1,
        SH_CUBE  = 3'd2,
        SH_QUART = 3'd3,
        SH_OUTQ  = 3'd4
    } t_shape;

    localparam int SHAPE_BITS = 3;

    typedef enum logic [1:0] {
        REG_START    = 2'd0,
        REG_END      = 2'd1,
        REG_DURATION = 2'd2,
        REG_MODE     = 2'd3
    } t_reg;

endpackage

[sv/pemu_in_if.sv]
interface pemu_in_if import pemu_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] elapsed_time;

    modport source (output valid, output elapsed_time, input ready);
    modport sink   (input valid, input elapsed_time, output ready);
endinterface

[sv/pemu_out_if.sv]
interface pemu_out_if import pemu_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] eased_value;
    logic                  finished;

    modport source (output valid, output eased_value, output finished, input ready);
    modport sink   (input valid, input eased_value, input finished, output ready);
endinterface

[sv/polynomial_easing_unit_core.sv]
// Polynomial easing unit.
// Configure start, end, duration and curve mode over the APB port while no
// beat is in flight; registers sit at byte offsets 0, 4, 8 and 12 and read back.
// Each beat on i_in carries an elapsed tick count; each returns exactly one
// beat on o_out with the eased value and a finished flag (tick >= duration).
// The pipeline has two front stages, FRAC_BITS restoring divider stages at one
// quotient bit each, three multiply stages for the curve power, one scale stage
// and the output register.
// Throughput is one beat per cycle; every stage has its own valid bit and
// loads whenever it is empty or its successor moves, so bubbles fill up.
// When the receiver stalls the output register holds its beat and the stages
// behind it keep filling; i_in.ready drops only once all of them are full.
// Synchronous active-low reset empties the pipeline and clears all
// configuration registers to zero.
`include "polynomial_easing_unit_core_defines.svh"

module polynomial_easing_unit_core import pemu_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    pemu_in_if.sink                  i_in,
    pemu_out_if.source               o_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int V      = VALUE_BITS;
    localparam int TB     = TIME_BITS;
    localparam int F      = FRAC_BITS;
    localparam int SIDE_W = 2 * V + SHAPE_BITS + 2;
    localparam int PW     = V + F + 2;

    // Configuration
    logic [V-1:0]  r_start;
    logic [V-1:0]  r_end;
    logic [TB-1:0] r_dur;
    t_mode         r_mode;
    logic          w_wr;
    t_reg          w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = t_reg'(paddr[APB_ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
            r_dur   <= '0;
            r_mode  <= MODE_LINEAR;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_START:    r_start <= pwdata[V-1:0];
                REG_END:      r_end   <= pwdata[V-1:0];
                REG_DURATION: r_dur   <= pwdata[TB-1:0];
                REG_MODE:     r_mode  <= t_mode'(pwdata[MODE_BITS-1:0]);
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_START:    prdata = APB_DATA_BITS'($signed(r_start));
            REG_END:      prdata = APB_DATA_BITS'($signed(r_end));
            REG_DURATION: prdata = APB_DATA_BITS'(r_dur);
            REG_MODE:     prdata = APB_DATA_BITS'(r_mode);
        endcase
    end

    // Front stage 0: done flag and 3t
    logic            r_f0_vld;
    logic [TB-1:0]   r_f0_t;
    logic [TB+1:0]   r_f0_t3;
    logic            r_f0_fin;
    logic            w_en_f0;
    logic            w_en_f1;

    assign w_en_f0  = !r_f0_vld || w_en_f1;
    assign i_in.ready = w_en_f0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_vld <= 1'b0;
        end else if (w_en_f0) begin
            r_f0_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_f0 && i_in.valid) begin
            r_f0_t   <= i_in.elapsed_time;
            r_f0_t3  <= {1'b0, i_in.elapsed_time, 1'b0} + {2'b00, i_in.elapsed_time};
            r_f0_fin <= (i_in.elapsed_time >= r_dur);
        end
    end

    // Front stage 1: segment, shape, base and slope
    logic            r_f1_vld;
    logic [TB-1:0]   r_f1_num;
    logic [SIDE_W-1:0] r_f1_side;
    logic            w_div_in_ready;
    logic            w_f1_rev;
    logic            w_f1_lt1;
    logic            w_f1_lt2;
    logic [TB+1:0]   w_f1_t3m;
    t_shape          w_f1_kind;
    logic [V-1:0]    w_f1_base;
    logic [V-1:0]    w_f1_targ;
    logic [TB-1:0]   w_f1_num;
    logic [V:0]      w_f1_delta;

    assign w_en_f1  = !r_f1_vld || w_div_in_ready;
    assign w_f1_rev = (r_mode >= MODE_R_IN_QUAD) && (r_mode <= MODE_POP);
    assign w_f1_lt1 = (r_f0_t3 < {2'b00, r_dur});
    assign w_f1_lt2 = (r_f0_t3 < {1'b0, r_dur, 1'b0});
    assign w_f1_t3m = r_f0_t3 - {1'b0, r_dur, 1'b0};

    always_comb begin
        w_f1_kind = SH_LIN;
        w_f1_base = r_start;
        w_f1_targ = r_end;
        w_f1_num  = r_f0_t;
        if (r_f0_fin) begin
            if (w_f1_rev) begin
                w_f1_targ = r_start;
            end else begin
                w_f1_base = r_end;
            end
        end else begin
            unique case (r_mode)
                MODE_IN_QUAD:  w_f1_kind = SH_QUAD;
                MODE_IN_CUBIC: w_f1_kind = SH_CUBE;
                MODE_IN_QUART: w_f1_kind = SH_QUART;
                MODE_OUT_QUAD: w_f1_kind = SH_OUTQ;
                MODE_R_IN_QUAD, MODE_R_IN_CUBIC, MODE_R_IN_QUART, MODE_R_OUT_QUAD: begin
                    w_f1_base = r_end;
                    w_f1_targ = r_start;
                    unique case (r_mode)
                        MODE_R_IN_QUAD:  w_f1_kind = SH_QUAD;
                        MODE_R_IN_CUBIC: w_f1_kind = SH_CUBE;
                        MODE_R_IN_QUART: w_f1_kind = SH_QUART;
                        default:         w_f1_kind = SH_OUTQ;
                    endcase
                end
                MODE_POP: begin
                    priority if (w_f1_lt1) begin
                        w_f1_kind = SH_OUTQ;
                        w_f1_num  = r_f0_t3[TB-1:0];
                    end else if (w_f1_lt2) begin
                        w_f1_base = r_end;
                    end else begin
                        w_f1_base = r_end;
                        w_f1_targ = r_start;
                        w_f1_kind = SH_QUAD;
                        w_f1_num  = w_f1_t3m[TB-1:0];
                    end
                end
                default: w_f1_kind = SH_LIN;
            endcase
        end
    end

    // Hold segments and done beats flat
    assign w_f1_delta = (r_f0_fin || (r_mode == MODE_POP && !w_f1_lt1 && w_f1_lt2))
                        ? '0
                        : ({w_f1_targ[V-1], w_f1_targ} - {w_f1_base[V-1], w_f1_base});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else if (w_en_f1) begin
            r_f1_vld <= r_f0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_f1 && r_f0_vld) begin
            r_f1_num  <= w_f1_num;
            r_f1_side <= {r_f0_fin, w_f1_kind, w_f1_base, w_f1_delta};
        end
    end

    // Normalized time u = num * 2^F / duration
    logic              w_div_vld;
    logic [F-1:0]      w_div_quo;
    logic [SIDE_W-1:0] w_div_side;
    logic              w_en_b0;

    pemu_div #(
        .TIME_BITS (TB),
        .FRAC_BITS (F),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_f1_vld),
        .o_in_ready  (w_div_in_ready),
        .i_num       (r_f1_num),
        .i_den       (r_dur),
        .i_side      (r_f1_side),
        .o_out_valid (w_div_vld),
        .i_out_ready (w_en_b0),
        .o_quo       (w_div_quo),
        .o_side      (w_div_side)
    );

    // Back stage 0: u*u or u*(2-u)
    logic              r_b0_vld;
    logic [F-1:0]      r_b0_u;
    logic [F-1:0]      r_b0_p1;
    logic [SIDE_W-1:0] r_b0_side;
    logic              w_en_b1;
    t_shape            w_b0_kind;
    logic [F+1:0]      w_b0_opb;
    logic [2*F+1:0]    w_b0_prod;

    assign w_en_b0   = !r_b0_vld || w_en_b1;
    assign w_b0_kind = t_shape'(w_div_side[2*V+SHAPE_BITS:2*V+1]);
    assign w_b0_opb  = (w_b0_kind == SH_OUTQ) ? ({2'b10, {F{1'b0}}} - {2'b00, w_div_quo})
                                              : {2'b00, w_div_quo};
    assign w_b0_prod = {{(F+2){1'b0}}, w_div_quo} * {{F{1'b0}}, w_b0_opb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_vld <= 1'b0;
        end else if (w_en_b0) begin
            r_b0_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b0 && w_div_vld) begin
            r_b0_u    <= w_div_quo;
            r_b0_p1   <= w_b0_prod[2*F-1:F];
            r_b0_side <= w_div_side;
        end
    end

    // Back stage 1: cube
    logic              r_b1_vld;
    logic [F-1:0]      r_b1_u;
    logic [F-1:0]      r_b1_p1;
    logic [F-1:0]      r_b1_p2;
    logic [SIDE_W-1:0] r_b1_side;
    logic              w_en_b2;
    logic [2*F-1:0]    w_b1_prod;

    assign w_en_b1   = !r_b1_vld || w_en_b2;
    assign w_b1_prod = {{F{1'b0}}, r_b0_p1} * {{F{1'b0}}, r_b0_u};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
        end else if (w_en_b1) begin
            r_b1_vld <= r_b0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b1 && r_b0_vld) begin
            r_b1_u    <= r_b0_u;
            r_b1_p1   <= r_b0_p1;
            r_b1_p2   <= w_b1_prod[2*F-1:F];
            r_b1_side <= r_b0_side;
        end
    end

    // Back stage 2: quart
    logic              r_b2_vld;
    logic [F-1:0]      r_b2_u;
    logic [F-1:0]      r_b2_p1;
    logic [F-1:0]      r_b2_p2;
    logic [F-1:0]      r_b2_p3;
    logic [SIDE_W-1:0] r_b2_side;
    logic              w_en_b3;
    logic [2*F-1:0]    w_b2_prod;

    assign w_en_b2   = !r_b2_vld || w_en_b3;
    assign w_b2_prod = {{F{1'b0}}, r_b1_p2} * {{F{1'b0}}, r_b1_u};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_vld <= 1'b0;
        end else if (w_en_b2) begin
            r_b2_vld <= r_b1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b2 && r_b1_vld) begin
            r_b2_u    <= r_b1_u;
            r_b2_p1   <= r_b1_p1;
            r_b2_p2   <= r_b1_p2;
            r_b2_p3   <= w_b2_prod[2*F-1:F];
            r_b2_side <= r_b1_side;
        end
    end

    // Back stage 3: pick the shape and scale by the slope
    logic                r_b3_vld;
    logic signed [PW-1:0] r_b3_prod;
    logic [V-1:0]        r_b3_base;
    logic                r_b3_fin;
    logic                w_en_out;
    t_shape              w_b3_kind;
    logic [V:0]          w_b3_delta;
    logic [F-1:0]        w_b3_p;
    logic signed [PW-1:0] w_b3_prod;

    assign w_en_b3    = !r_b3_vld || w_en_out;
    assign w_b3_kind  = t_shape'(r_b2_side[2*V+SHAPE_BITS:2*V+1]);
    assign w_b3_delta = r_b2_side[V:0];

    always_comb begin
        unique case (w_b3_kind)
            SH_QUAD, SH_OUTQ: w_b3_p = r_b2_p1;
            SH_CUBE:          w_b3_p = r_b2_p2;
            SH_QUART:         w_b3_p = r_b2_p3;
            default:          w_b3_p = r_b2_u;
        endcase
    end

    assign w_b3_prod = $signed({{(F+1){w_b3_delta[V]}}, w_b3_delta})
                     * $signed({{(V+2){1'b0}}, w_b3_p});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b3_vld <= 1'b0;
        end else if (w_en_b3) begin
            r_b3_vld <= r_b2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b3 && r_b2_vld) begin
            r_b3_prod <= w_b3_prod;
            r_b3_base <= r_b2_side[2*V:V+1];
            r_b3_fin  <= r_b2_side[SIDE_W-1];
        end
    end

    // Output register: round half up and add the base
    logic                r_out_vld;
    logic [V-1:0]        r_out_val;
    logic                r_out_fin;
    logic signed [PW-1:0] w_out_rnd;
    logic [V+1:0]        w_out_sum;

    assign w_en_out  = !r_out_vld || o_out.ready;
    assign w_out_rnd = r_b3_prod + $signed({{(V+2){1'b0}}, 1'b1, {(F-1){1'b0}}});
    assign w_out_sum = {{2{r_b3_base[V-1]}}, r_b3_base} + w_out_rnd[PW-1:F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en_out) begin
            r_out_vld <= r_b3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out && r_b3_vld) begin
            r_out_val <= w_out_sum[V-1:0];
            r_out_fin <= r_b3_fin;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.eased_value = r_out_val;
    assign o_out.finished    = r_out_fin;

    `PEMU_ASSERT_NOW(a_in_stall_full, i_clk, i_rst_n, !i_in.ready, r_f0_vld, "input stalled with empty front stage")
    `PEMU_ASSERT_NEXT(a_f1_hold, i_clk, i_rst_n, r_f1_vld && !w_div_in_ready, r_f1_vld && $stable(r_f1_num) && $stable(r_f1_side), "front beat lost or changed while divider stalled")
    `PEMU_ASSERT_NOW(a_done_flat, i_clk, i_rst_n, r_b3_vld && r_b3_fin, r_b3_prod == '0, "finished beat carries nonzero slope product")

endmodule

[sv/pemu_div.sv]
module pemu_div import pemu_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [TIME_BITS-1:0] i_num,
    input  logic [TIME_BITS-1:0] i_den,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [FRAC_BITS-1:0] o_quo,
    output logic [SIDE_W-1:0]    o_side
);

    logic                 r_vld  [FRAC_BITS];
    logic [TIME_BITS-1:0] r_rem  [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_quo  [FRAC_BITS];
    logic [SIDE_W-1:0]    r_side [FRAC_BITS];
    logic                 w_en   [FRAC_BITS];

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stg
        logic [TIME_BITS-1:0] w_prem;
        logic [FRAC_BITS-1:0] w_pquo;
        logic [SIDE_W-1:0]    w_pside;
        logic                 w_pvld;
        logic                 w_nxt_en;
        logic [TIME_BITS:0]   w_rem2;
        logic [TIME_BITS:0]   w_diff;
        logic                 w_ge;

        if (k == 0) begin : g_first
            assign w_prem  = i_num;
            assign w_pquo  = '0;
            assign w_pside = i_side;
            assign w_pvld  = i_in_valid;
        end else begin : g_rest
            assign w_prem  = r_rem[k-1];
            assign w_pquo  = r_quo[k-1];
            assign w_pside = r_side[k-1];
            assign w_pvld  = r_vld[k-1];
        end

        if (k == FRAC_BITS - 1) begin : g_last
            assign w_nxt_en = i_out_ready;
        end else begin : g_mid
            assign w_nxt_en = w_en[k+1];
        end

        assign w_en[k] = !r_vld[k] || w_nxt_en;
        assign w_rem2  = {w_prem, 1'b0};
        assign w_ge    = (w_rem2 >= {1'b0, i_den});
        assign w_diff  = w_rem2 - {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_vld[k] <= w_pvld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k] && w_pvld) begin
                r_rem[k]  <= w_ge ? w_diff[TIME_BITS-1:0] : w_rem2[TIME_BITS-1:0];
                r_quo[k]  <= {w_pquo[FRAC_BITS-2:0], w_ge};
                r_side[k] <= w_pside;
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[FRAC_BITS-1];
    assign o_quo       = r_quo[FRAC_BITS-1];
    assign o_side      = r_side[FRAC_BITS-1];

endmodule

[test/tb.sv]
module tb;
    import pemu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ONE         = 1 << FRAC_BITS_DEF;

    typedef struct packed {
        logic [TIME_BITS_DEF-1:0]  tick;
        logic [VALUE_BITS_DEF-1:0] value;
        logic                      done;
    } t_eased_beat;

    class ease_scoreboard;
        logic signed [VALUE_BITS_DEF-1:0] start_v;
        logic signed [VALUE_BITS_DEF-1:0] end_v;
        logic [TIME_BITS_DEF-1:0]         dur;
        logic [MODE_BITS-1:0]             mode;
        t_eased_beat                      pending_eased[$];
        int                               errors;

        function new();
            start_v = '0;
            end_v   = '0;
            dur     = '0;
            mode    = '0;
            errors  = 0;
        endfunction

        function void set_reg(t_reg r, logic [APB_DATA_BITS-1:0] data);
            case (r)
                REG_START:    start_v = data[VALUE_BITS_DEF-1:0];
                REG_END:      end_v   = data[VALUE_BITS_DEF-1:0];
                REG_DURATION: dur     = data[TIME_BITS_DEF-1:0];
                default:      mode    = data[MODE_BITS-1:0];
            endcase
        endfunction

        static function longint qmul(longint a, longint b);
            return (a * b) >> FRAC_BITS_DEF;
        endfunction

        static function longint curve(t_shape k, longint u);
            case (k)
                SH_QUAD:  return qmul(u, u);
                SH_CUBE:  return qmul(qmul(u, u), u);
                SH_QUART: return qmul(qmul(qmul(u, u), u), u);
                SH_OUTQ:  return qmul(u, 2 * ONE - u);
                default:  return u;
            endcase
        endfunction

        static function longint mix(longint base, longint target, longint p);
            longint prod;
            prod = (target - base) * p + ONE / 2;
            return base + (prod >>> FRAC_BITS_DEF);
        endfunction

        function void note_tick(logic [TIME_BITS_DEF-1:0] t);
            t_eased_beat e;
            longint      tt, d, s, en, u, t3, v;
            logic        rev;
            tt  = longint'(t);
            d   = longint'(dur);
            s   = longint'(start_v);
            en  = longint'(end_v);
            rev = (mode >= MODE_R_IN_QUAD) && (mode <= MODE_POP);
            e.tick = t;
            e.done = (tt >= d);
            if (tt >= d) begin
                v = rev ? s : en;
            end else if (mode == MODE_POP) begin
                t3 = 3 * tt;
                if (t3 < d) begin
                    u = (t3 << FRAC_BITS_DEF) / d;
                    v = mix(s, en, curve(SH_OUTQ, u));
                end else if (t3 < 2 * d) begin
                    v = en;
                end else begin
                    u = ((t3 - 2 * d) << FRAC_BITS_DEF) / d;
                    v = mix(en, s, curve(SH_QUAD, u));
                end
            end else begin
                u = (tt << FRAC_BITS_DEF) / d;
                if (rev)
                    v = mix(en, s, curve(t_shape'(SHAPE_BITS'(mode - MODE_OUT_QUAD)), u));
                else if (mode <= MODE_OUT_QUAD)
                    v = mix(s, en, curve(t_shape'(mode[SHAPE_BITS-1:0]), u));
                else
                    v = mix(s, en, u);
            end
            e.value = v[VALUE_BITS_DEF-1:0];
            pending_eased.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_beat(logic [VALUE_BITS_DEF-1:0] v, logic f);
            t_eased_beat e;
            if (pending_eased.size() == 0) begin
                report($sformatf("unexpected beat value=%h finished=%b", v, f));
            end else begin
                e = pending_eased.pop_front();
                if (v !== e.value)
                    report($sformatf("tick=%0d value %h, want %h", e.tick, v, e.value));
                if (f !== e.done)
                    report($sformatf("tick=%0d finished %b, want %b", e.tick, f, e.done));
            end
        endtask
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    pemu_in_if  in_if ();
    pemu_out_if out_if ();

    polynomial_easing_unit_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ease_scoreboard board = new();
    int             send_idle;
    int             recv_idle;
    int             stall_left;
    int             cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else begin
                out_if.ready = ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            board.check_beat(out_if.eased_value, out_if.finished);
    end

    task drain();
        in_if.valid = 1'b0;
        while (board.pending_eased.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task reg_write(t_reg r, logic [APB_DATA_BITS-1:0] data);
        drain();
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = APB_ADDR_BITS'({r, 2'b00});
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_reg(r, data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task set_config(logic [15:0] s, logic [15:0] e, logic [15:0] d, logic [3:0] m);
        reg_write(REG_START, {16'd0, s});
        reg_write(REG_END, {16'd0, e});
        reg_write(REG_DURATION, {16'd0, d});
        reg_write(REG_MODE, {28'd0, m});
    endtask

    task send_tick(logic [TIME_BITS_DEF-1:0] t);
        while ($urandom_range(0, 99) < send_idle) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        = 1'b1;
        in_if.elapsed_time = t;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_tick(t);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task rand_config();
        logic [15:0] d;
        logic [3:0]  m;
        case ($urandom_range(0, 9))
            0:       d = 16'd0;
            1:       d = 16'd1;
            2:       d = 16'($urandom_range(2, 3));
            3:       d = 16'hffff;
            4, 5:    d = 16'($urandom_range(2, 100));
            default: d = 16'($urandom);
        endcase
        if ($urandom_range(0, 4) == 0)
            m = 4'($urandom_range(0, 15));
        else
            m = 4'($urandom_range(0, int'(MODE_POP)));
        set_config(pick_value(), pick_value(), d, m);
    endtask

    function automatic logic [15:0] pick_tick();
        int d;
        d = int'(board.dur);
        if (d == 0)
            return 16'($urandom);
        case ($urandom_range(0, 11))
            0:       return 16'($urandom);
            1:       return 16'(d);
            2:       return 16'(d - 1);
            3:       return 16'd0;
            4:       return 16'hffff;
            5:       return 16'(d / 3);
            6:       return 16'((2 * d) / 3);
            7:       return 16'(d + $urandom_range(0, 3));
            default: return 16'($urandom_range(0, d - 1));
        endcase
    endfunction

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_if.valid        = 1'b0;
        in_if.elapsed_time = '0;
        send_idle          = 20;
        recv_idle          = 20;
        stall_left         = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_tick(16'h0000);
        send_tick(16'hffff);
        set_config(16'h8000, 16'h7fff, 16'hffff, MODE_LINEAR);
        send_tick(16'h0000);
        send_tick(16'hfffe);
        for (int m = 0; m < 16; m++) begin
            reg_write(REG_MODE, m);
            send_tick(16'd43690);
        end
        reg_write(REG_MODE, {28'd0, MODE_POP});
        send_tick(16'd21844);
        send_tick(16'd21845);
        set_config(16'h7fff, 16'h8000, 16'd0, MODE_R_IN_QUAD);
        send_tick(16'h0000);
        set_config(16'h1234, 16'hedcb, 16'd1, 4'($urandom_range(int'(MODE_POP) + 1, 15)));
        send_tick(16'h0000);
        send_tick(16'h0001);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle = 32;
                    recv_idle = 62;
                end
                1: begin
                    send_idle = 62;
                    recv_idle = 32;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int blk = 0; blk < 11; blk++) begin
                rand_config();
                if (ph == 2 && blk == 0)
                    stall_left = 300;
                repeat (60) send_tick(pick_tick());
            end
        end

        drain();
        repeat (30) @(posedge i_clk);
        if (board.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
